[rtl/kosaraju_scc_labeler_unit_assert.svh]
// assertion macros shared by the scc labeler rtl
`ifndef KOSARAJU_SCC_LABELER_UNIT_ASSERT_SVH
`define KOSARAJU_SCC_LABELER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define KSCC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KSCC_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/kscc_pkg.sv]
// constants, types and state codes of the scc labeler
`timescale 1ns / 1ps
package kscc_pkg;

	localparam int MAX_V  = 1024;
	localparam int MAX_E  = 4096;
	localparam int VW     = 11;          // vertex id width
	localparam int CW     = 13;          // edge count / offset width
	localparam int EAW    = 12;          // edge store address
	localparam int OFS_D  = MAX_V + 2;   // offset table depth
	localparam int OAW    = 11;          // offset table address
	localparam int LAW    = 10;          // stack / listing address

	typedef struct packed {
		logic [VW-1:0] vtx;
		logic [CW-1:0] pos;
		logic [CW-1:0] lim;
	} stk_entry_t;

	localparam int STK_W = $bits(stk_entry_t);

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_READ  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_VERTEX  = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD1, ST_RD2,
		ST_CLR, ST_CNT_RD, ST_CNT_A, ST_CNT_B,
		ST_PFX_RD, ST_PFX_W,
		ST_FIL_RD, ST_FIL_A, ST_FIL_B,
		ST_REV_U, ST_REV_U2, ST_REV_P, ST_REV_T, ST_REV_W,
		ST_ROOT, ST_ROOT_C, ST_OFS1, ST_OFS2,
		ST_TOP, ST_TGT, ST_SEEN, ST_POP,
		ST_CLR2, ST_K_RD, ST_K_A, ST_K_B, ST_DONE
	} state_t;

endpackage

[rtl/kscc_ram.sv]
// simple dual-port synchronous ram, one write and one registered read
`timescale 1ns / 1ps
module kscc_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	localparam int AW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/kosaraju_scc_labeler_unit.sv]
// top level of the kosaraju scc labeler: sequencer and graph memories
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------
//  in      | in_valid / in_stall     | mode, edge_from, edge_to
//  out     | out_valid / out_stall   | kind, component_total, edges_dropped,
//          |                         | vertex_id, component_number,
//          |                         | ends_component, ends_listing
//  cfg     | cfg_wr_en               | cfg_wr_data (vertex_count)
//
// add edge and clear are done in the idle state; a vertex read goes through the
// states rd1 and rd2 before the result register is loaded. a run builds the
// forward and reverse lists and then makes two search passes; every step goes
// through a simple dual-port graph memory with a registered read.
// the seen marks are swept at the start of each pass as part of the run.
// reset (arst_n low) empties the edge store and the listing; in_stall is high
// while an item is at work or the result register is held by out_stall.
`timescale 1ns / 1ps
`include "kosaraju_scc_labeler_unit_assert.svh"
module kosaraju_scc_labeler_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [kscc_pkg::VW-1:0] cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              mode,
	input  logic [kscc_pkg::VW-1:0] edge_from,
	input  logic [kscc_pkg::VW-1:0] edge_to,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    kind,
	output logic [kscc_pkg::VW-1:0] component_total,
	output logic                    edges_dropped,
	output logic [kscc_pkg::VW-1:0] vertex_id,
	output logic [kscc_pkg::VW-1:0] component_number,
	output logic                    ends_component,
	output logic                    ends_listing
);
	import kscc_pkg::*;

	// control registers
	state_t          state_q, state_d;
	logic [CW-1:0]   et_q;
	logic            drop_q;
	logic [VW-1:0]   vc_q;
	logic [VW-1:0]   rp_q;
	logic            ready_q;
	logic [VW-1:0]   len_q;
	logic            out_valid_q;

	// datapath registers
	logic [CW-1:0]   idx_q;
	logic [VW-1:0]   s_q, d_q, v_q;
	logic [CW-1:0]   accf_q, accr_q, lo_q;
	logic [VW-1:0]   tos_u_q;
	logic [CW-1:0]   tos_p_q, tos_hi_q;
	logic [VW-1:0]   depth_q, done_q, lcnt_q, comp_q;
	logic            pass_q;
	logic [VW-1:0]   rv_q, rc_q;
	logic            o_kind_q, o_drop_q, o_endc_q, o_endl_q;
	logic [VW-1:0]   o_total_q, o_vtx_q, o_comp_q;

	// memory ports
	logic            esrc_we, edst_we;
	logic [EAW-1:0]  esrc_wa, esrc_ra, edst_wa, edst_ra;
	logic [VW-1:0]   esrc_wd, edst_wd, esrc_rd, edst_rd;
	logic            fofs_we, rofs_we, fcur_we, rcur_we;
	logic [OAW-1:0]  fofs_wa, fofs_ra, rofs_wa, rofs_ra;
	logic [OAW-1:0]  fcur_wa, fcur_ra, rcur_wa, rcur_ra;
	logic [CW-1:0]   fofs_wd, fofs_rd, rofs_wd, rofs_rd;
	logic [CW-1:0]   fcur_wd, fcur_rd, rcur_wd, rcur_rd;
	logic            ftgt_we, rtgt_we;
	logic [EAW-1:0]  ftgt_wa, ftgt_ra, rtgt_wa, rtgt_ra;
	logic [VW-1:0]   ftgt_wd, ftgt_rd, rtgt_wd, rtgt_rd;
	logic            seen_we, seen_wd, seen_rd;
	logic [OAW-1:0]  seen_wa, seen_ra;
	logic            fin_we;
	logic [LAW-1:0]  fin_wa, fin_ra;
	logic [VW-1:0]   fin_wd, fin_rd;
	logic            stk_we;
	logic [LAW-1:0]  stk_wa, stk_ra;
	stk_entry_t      stk_wd, stk_rd;
	logic            lv_we, lc_we;
	logic [LAW-1:0]  lv_wa, lv_ra, lc_wa, lc_ra;
	logic [VW-1:0]   lv_wd, lv_rd, lc_wd, lc_rd;

	// helper terms
	mode_t           mode_w;
	logic [VW-1:0]   n_w;
	logic [CW-1:0]   n_ext, n_p1;
	logic            in_acc, add_ok, rd_ok, ev_w, p_lt, can_push, out_load, last_w;
	logic [CW-1:0]   ofs_rd, nf_w, nr_w, idx_m1;
	logic [VW-1:0]   tgt_rd, dep_m1, dep_m2, rp_p1;

	assign mode_w   = mode_t'(mode);
	assign n_w      = (vc_q > VW'(MAX_V)) ? VW'(MAX_V) : vc_q;
	assign n_ext    = CW'(n_w);
	assign n_p1     = n_ext + CW'(1);
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign add_ok   = (edge_from != '0) && (edge_from <= n_w) && (edge_to != '0)
		&& (edge_to <= n_w) && (et_q < CW'(MAX_E));
	assign rd_ok    = ready_q && (rp_q < len_q);
	assign ev_w     = (s_q != '0) && (s_q <= n_w) && (d_q != '0) && (d_q <= n_w);
	assign ofs_rd   = pass_q ? rofs_rd : fofs_rd;
	assign tgt_rd   = pass_q ? rtgt_rd : ftgt_rd;
	assign p_lt     = tos_p_q < tos_hi_q;
	assign can_push = !seen_rd && (depth_q < VW'(MAX_V)) && (!pass_q || lcnt_q < VW'(MAX_V));
	assign nf_w     = accf_q + fofs_rd;
	assign nr_w     = accr_q + rofs_rd;
	assign idx_m1   = idx_q - CW'(1);
	assign dep_m1   = depth_q - VW'(1);
	assign dep_m2   = depth_q - VW'(2);
	assign rp_p1    = rp_q + VW'(1);
	assign last_w   = rp_p1 == len_q;
	assign out_load = (state_q == ST_RD2) || (state_q == ST_DONE);

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		esrc_we = 1'b0; esrc_wa = '0; esrc_wd = '0; esrc_ra = '0;
		edst_we = 1'b0; edst_wa = '0; edst_wd = '0; edst_ra = '0;
		fofs_we = 1'b0; fofs_wa = '0; fofs_wd = '0; fofs_ra = '0;
		rofs_we = 1'b0; rofs_wa = '0; rofs_wd = '0; rofs_ra = '0;
		fcur_we = 1'b0; fcur_wa = '0; fcur_wd = '0; fcur_ra = '0;
		rcur_we = 1'b0; rcur_wa = '0; rcur_wd = '0; rcur_ra = '0;
		ftgt_we = 1'b0; ftgt_wa = '0; ftgt_wd = '0; ftgt_ra = '0;
		rtgt_we = 1'b0; rtgt_wa = '0; rtgt_wd = '0; rtgt_ra = '0;
		seen_we = 1'b0; seen_wa = '0; seen_wd = 1'b0; seen_ra = '0;
		fin_we  = 1'b0; fin_wa  = '0; fin_wd  = '0; fin_ra  = '0;
		stk_we  = 1'b0; stk_wa  = '0; stk_wd  = '0; stk_ra  = '0;
		lv_we   = 1'b0; lv_wa   = '0; lv_wd   = '0; lv_ra   = '0;
		lc_we   = 1'b0; lc_wa   = '0; lc_wd   = '0; lc_ra   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (mode_w)
						MODE_ADD: begin
							if (add_ok) begin
								esrc_we = 1'b1; esrc_wa = et_q[EAW-1:0]; esrc_wd = edge_from;
								edst_we = 1'b1; edst_wa = et_q[EAW-1:0]; edst_wd = edge_to;
							end
						end
						MODE_RUN: begin
							state_d = ST_CLR;
						end
						MODE_READ: begin
							if (rd_ok) begin
								lv_ra   = rp_q[LAW-1:0];
								lc_ra   = rp_q[LAW-1:0];
								state_d = ST_RD1;
							end
						end
						MODE_CLEAR: begin
						end
					endcase
				end
			end
			ST_RD1: begin
				lc_ra   = rp_p1[LAW-1:0];
				state_d = ST_RD2;
			end
			ST_RD2: begin
				state_d = ST_IDLE;
			end
			// clear counts and seen marks
			ST_CLR: begin
				fofs_we = 1'b1; fofs_wa = idx_q[OAW-1:0];
				rofs_we = 1'b1; rofs_wa = idx_q[OAW-1:0];
				seen_we = 1'b1; seen_wa = idx_q[OAW-1:0];
				if (idx_q == n_p1) begin
					state_d = ST_CNT_RD;
				end
			end
			// count out and in degrees
			ST_CNT_RD: begin
				if (idx_q == et_q) begin
					state_d = ST_PFX_RD;
				end else begin
					esrc_ra = idx_q[EAW-1:0];
					edst_ra = idx_q[EAW-1:0];
					state_d = ST_CNT_A;
				end
			end
			ST_CNT_A: begin
				fofs_ra = esrc_rd + VW'(1);
				rofs_ra = edst_rd + VW'(1);
				state_d = ST_CNT_B;
			end
			ST_CNT_B: begin
				if (ev_w) begin
					fofs_we = 1'b1; fofs_wa = s_q + VW'(1); fofs_wd = fofs_rd + CW'(1);
					rofs_we = 1'b1; rofs_wa = d_q + VW'(1); rofs_wd = rofs_rd + CW'(1);
				end
				state_d = ST_CNT_RD;
			end
			// running sums into offsets and fill cursors
			ST_PFX_RD: begin
				fofs_ra = idx_q[OAW-1:0];
				rofs_ra = idx_q[OAW-1:0];
				state_d = ST_PFX_W;
			end
			ST_PFX_W: begin
				fofs_we = 1'b1; fofs_wa = idx_q[OAW-1:0]; fofs_wd = nf_w;
				fcur_we = 1'b1; fcur_wa = idx_q[OAW-1:0]; fcur_wd = nf_w;
				rofs_we = 1'b1; rofs_wa = idx_q[OAW-1:0]; rofs_wd = nr_w;
				rcur_we = 1'b1; rcur_wa = idx_q[OAW-1:0]; rcur_wd = nr_w;
				state_d = (idx_q == n_p1) ? ST_FIL_RD : ST_PFX_RD;
			end
			// forward lists in insertion order
			ST_FIL_RD: begin
				if (idx_q == et_q) begin
					state_d = ST_REV_U;
				end else begin
					esrc_ra = idx_q[EAW-1:0];
					edst_ra = idx_q[EAW-1:0];
					state_d = ST_FIL_A;
				end
			end
			ST_FIL_A: begin
				fcur_ra = esrc_rd;
				state_d = ST_FIL_B;
			end
			ST_FIL_B: begin
				if (ev_w) begin
					ftgt_we = 1'b1; ftgt_wa = fcur_rd[EAW-1:0]; ftgt_wd = d_q;
					fcur_we = 1'b1; fcur_wa = s_q; fcur_wd = fcur_rd + CW'(1);
				end
				state_d = ST_FIL_RD;
			end
			// reverse lists, sources ascending
			ST_REV_U: begin
				if (idx_q > n_ext) begin
					state_d = ST_ROOT;
				end else begin
					fofs_ra = idx_q[OAW-1:0] + OAW'(1);
					state_d = ST_REV_U2;
				end
			end
			ST_REV_U2: begin
				state_d = ST_REV_P;
			end
			ST_REV_P: begin
				if (p_lt) begin
					ftgt_ra = tos_p_q[EAW-1:0];
					state_d = ST_REV_T;
				end else begin
					state_d = ST_REV_U;
				end
			end
			ST_REV_T: begin
				rcur_ra = ftgt_rd;
				state_d = ST_REV_W;
			end
			ST_REV_W: begin
				rtgt_we = 1'b1; rtgt_wa = rcur_rd[EAW-1:0]; rtgt_wd = idx_q[VW-1:0];
				rcur_we = 1'b1; rcur_wa = v_q; rcur_wd = rcur_rd + CW'(1);
				state_d = ST_REV_P;
			end
			// first pass roots
			ST_ROOT: begin
				if (idx_q > n_ext) begin
					state_d = ST_CLR2;
				end else begin
					seen_ra = idx_q[OAW-1:0];
					state_d = ST_ROOT_C;
				end
			end
			ST_ROOT_C: begin
				if (seen_rd) begin
					state_d = ST_ROOT;
				end else begin
					seen_we = 1'b1; seen_wa = idx_q[OAW-1:0]; seen_wd = 1'b1;
					fofs_ra = idx_q[OAW-1:0];
					rofs_ra = idx_q[OAW-1:0];
					state_d = ST_OFS1;
				end
			end
			// fetch list bounds of the new top
			ST_OFS1: begin
				fofs_ra = tos_u_q + VW'(1);
				rofs_ra = tos_u_q + VW'(1);
				state_d = ST_OFS2;
			end
			ST_OFS2: begin
				state_d = ST_TOP;
			end
			// step the top of the walk
			ST_TOP: begin
				if (p_lt) begin
					ftgt_ra = tos_p_q[EAW-1:0];
					rtgt_ra = tos_p_q[EAW-1:0];
					state_d = ST_TGT;
				end else begin
					if (!pass_q && done_q < VW'(MAX_V)) begin
						fin_we = 1'b1; fin_wa = done_q[LAW-1:0]; fin_wd = tos_u_q;
					end
					if (depth_q == VW'(1)) begin
						state_d = pass_q ? ST_K_RD : ST_ROOT;
					end else begin
						stk_ra  = dep_m2[LAW-1:0];
						state_d = ST_POP;
					end
				end
			end
			ST_TGT: begin
				seen_ra = tgt_rd;
				state_d = ST_SEEN;
			end
			ST_SEEN: begin
				if (can_push) begin
					seen_we = 1'b1; seen_wa = v_q; seen_wd = 1'b1;
					stk_we  = 1'b1; stk_wa = dep_m1[LAW-1:0];
					stk_wd  = '{vtx: tos_u_q, pos: tos_p_q, lim: tos_hi_q};
					fofs_ra = v_q;
					rofs_ra = v_q;
					if (pass_q) begin
						lv_we = 1'b1; lv_wa = lcnt_q[LAW-1:0]; lv_wd = v_q;
						lc_we = 1'b1; lc_wa = lcnt_q[LAW-1:0]; lc_wd = comp_q;
					end
					state_d = ST_OFS1;
				end else begin
					state_d = ST_TOP;
				end
			end
			ST_POP: begin
				state_d = ST_TOP;
			end
			// clear seen marks for the second pass
			ST_CLR2: begin
				seen_we = 1'b1; seen_wa = idx_q[OAW-1:0];
				if (idx_q == n_ext) begin
					state_d = ST_K_RD;
				end
			end
			// second pass roots in decreasing finish order
			ST_K_RD: begin
				if (idx_q == '0) begin
					state_d = ST_DONE;
				end else begin
					fin_ra  = idx_m1[LAW-1:0];
					state_d = ST_K_A;
				end
			end
			ST_K_A: begin
				seen_ra = fin_rd;
				state_d = ST_K_B;
			end
			ST_K_B: begin
				if (seen_rd) begin
					state_d = ST_K_RD;
				end else begin
					seen_we = 1'b1; seen_wa = v_q; seen_wd = 1'b1;
					lv_we   = 1'b1; lv_wa = lcnt_q[LAW-1:0]; lv_wd = v_q;
					lc_we   = 1'b1; lc_wa = lcnt_q[LAW-1:0]; lc_wd = comp_q + VW'(1);
					fofs_ra = v_q;
					rofs_ra = v_q;
					state_d = ST_OFS1;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			et_q        <= '0;
			drop_q      <= 1'b0;
			vc_q        <= VW'(1);
			rp_q        <= '0;
			ready_q     <= 1'b0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				vc_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE && in_acc) begin
				if (mode_w == MODE_ADD) begin
					if (add_ok) begin
						et_q <= et_q + CW'(1);
					end else begin
						drop_q <= 1'b1;
					end
				end else if (mode_w == MODE_CLEAR) begin
					et_q   <= '0;
					drop_q <= 1'b0;
				end
			end
			if (state_q == ST_RD2) begin
				rp_q <= rp_p1;
			end
			if (state_q == ST_DONE) begin
				len_q   <= lcnt_q;
				rp_q    <= '0;
				ready_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				idx_q <= '0;
			end
			ST_RD1: begin
				rv_q <= lv_rd;
				rc_q <= lc_rd;
			end
			ST_RD2: begin
				o_kind_q  <= KIND_VERTEX;
				o_total_q <= '0;
				o_drop_q  <= drop_q;
				o_vtx_q   <= rv_q;
				o_comp_q  <= rc_q;
				o_endc_q  <= last_w || (lc_rd != rc_q);
				o_endl_q  <= last_w;
			end
			ST_CLR: begin
				idx_q <= (idx_q == n_p1) ? '0 : idx_q + CW'(1);
			end
			ST_CNT_RD: begin
				if (idx_q == et_q) begin
					idx_q  <= CW'(1);
					accf_q <= '0;
					accr_q <= '0;
				end
			end
			ST_CNT_A, ST_FIL_A: begin
				s_q <= esrc_rd;
				d_q <= edst_rd;
			end
			ST_CNT_B, ST_FIL_B: begin
				idx_q <= idx_q + CW'(1);
			end
			ST_PFX_RD: begin
			end
			ST_PFX_W: begin
				accf_q <= nf_w;
				accr_q <= nr_w;
				idx_q  <= (idx_q == n_p1) ? '0 : idx_q + CW'(1);
			end
			ST_FIL_RD: begin
				if (idx_q == et_q) begin
					idx_q <= CW'(1);
					lo_q  <= '0;
				end
			end
			ST_REV_U: begin
				if (idx_q > n_ext) begin
					idx_q  <= CW'(1);
					done_q <= '0;
					pass_q <= 1'b0;
				end
			end
			ST_REV_U2: begin
				tos_hi_q <= fofs_rd;
				tos_p_q  <= lo_q;
			end
			ST_REV_P: begin
				if (!p_lt) begin
					lo_q  <= tos_hi_q;
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_REV_T: begin
				v_q <= ftgt_rd;
			end
			ST_REV_W: begin
				tos_p_q <= tos_p_q + CW'(1);
			end
			ST_ROOT: begin
				if (idx_q > n_ext) begin
					idx_q <= '0;
				end
			end
			ST_ROOT_C: begin
				if (seen_rd) begin
					idx_q <= idx_q + CW'(1);
				end else begin
					tos_u_q <= idx_q[VW-1:0];
					depth_q <= VW'(1);
				end
			end
			ST_OFS1: begin
				tos_p_q <= ofs_rd;
			end
			ST_OFS2: begin
				tos_hi_q <= ofs_rd;
			end
			ST_TOP: begin
				if (!p_lt) begin
					if (!pass_q && done_q < VW'(MAX_V)) begin
						done_q <= done_q + VW'(1);
					end
					depth_q <= dep_m1;
					if (depth_q == VW'(1)) begin
						idx_q <= pass_q ? idx_m1 : idx_q + CW'(1);
					end
				end
			end
			ST_TGT: begin
				v_q     <= tgt_rd;
				tos_p_q <= tos_p_q + CW'(1);
			end
			ST_SEEN: begin
				if (can_push) begin
					tos_u_q <= v_q;
					depth_q <= depth_q + VW'(1);
					if (pass_q) begin
						lcnt_q <= lcnt_q + VW'(1);
					end
				end
			end
			ST_POP: begin
				tos_u_q  <= stk_rd.vtx;
				tos_p_q  <= stk_rd.pos;
				tos_hi_q <= stk_rd.lim;
			end
			ST_CLR2: begin
				if (idx_q == n_ext) begin
					idx_q  <= CW'(done_q);
					comp_q <= '0;
					lcnt_q <= '0;
					pass_q <= 1'b1;
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_K_RD: begin
			end
			ST_K_A: begin
				v_q <= fin_rd;
			end
			ST_K_B: begin
				if (seen_rd) begin
					idx_q <= idx_m1;
				end else begin
					comp_q  <= comp_q + VW'(1);
					lcnt_q  <= lcnt_q + VW'(1);
					tos_u_q <= v_q;
					depth_q <= VW'(1);
				end
			end
			ST_DONE: begin
				o_kind_q  <= KIND_SUMMARY;
				o_total_q <= comp_q;
				o_drop_q  <= drop_q;
				o_vtx_q   <= '0;
				o_comp_q  <= '0;
				o_endc_q  <= 1'b0;
				o_endl_q  <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	// graph memories
	kscc_ram #(.Width(VW), .Depth(MAX_E)) u_esrc (.clk(clk), .we(esrc_we), .waddr(esrc_wa),
		.wdata(esrc_wd), .raddr(esrc_ra), .rdata(esrc_rd));
	kscc_ram #(.Width(VW), .Depth(MAX_E)) u_edst (.clk(clk), .we(edst_we), .waddr(edst_wa),
		.wdata(edst_wd), .raddr(edst_ra), .rdata(edst_rd));
	kscc_ram #(.Width(CW), .Depth(OFS_D)) u_fofs (.clk(clk), .we(fofs_we), .waddr(fofs_wa),
		.wdata(fofs_wd), .raddr(fofs_ra), .rdata(fofs_rd));
	kscc_ram #(.Width(CW), .Depth(OFS_D)) u_rofs (.clk(clk), .we(rofs_we), .waddr(rofs_wa),
		.wdata(rofs_wd), .raddr(rofs_ra), .rdata(rofs_rd));
	kscc_ram #(.Width(CW), .Depth(OFS_D)) u_fcur (.clk(clk), .we(fcur_we), .waddr(fcur_wa),
		.wdata(fcur_wd), .raddr(fcur_ra), .rdata(fcur_rd));
	kscc_ram #(.Width(CW), .Depth(OFS_D)) u_rcur (.clk(clk), .we(rcur_we), .waddr(rcur_wa),
		.wdata(rcur_wd), .raddr(rcur_ra), .rdata(rcur_rd));
	kscc_ram #(.Width(VW), .Depth(MAX_E)) u_ftgt (.clk(clk), .we(ftgt_we), .waddr(ftgt_wa),
		.wdata(ftgt_wd), .raddr(ftgt_ra), .rdata(ftgt_rd));
	kscc_ram #(.Width(VW), .Depth(MAX_E)) u_rtgt (.clk(clk), .we(rtgt_we), .waddr(rtgt_wa),
		.wdata(rtgt_wd), .raddr(rtgt_ra), .rdata(rtgt_rd));
	kscc_ram #(.Width(1), .Depth(OFS_D)) u_seen (.clk(clk), .we(seen_we), .waddr(seen_wa),
		.wdata(seen_wd), .raddr(seen_ra), .rdata(seen_rd));
	kscc_ram #(.Width(VW), .Depth(MAX_V)) u_fin (.clk(clk), .we(fin_we), .waddr(fin_wa),
		.wdata(fin_wd), .raddr(fin_ra), .rdata(fin_rd));
	kscc_ram #(.Width(STK_W), .Depth(MAX_V)) u_stk (.clk(clk), .we(stk_we), .waddr(stk_wa),
		.wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));
	kscc_ram #(.Width(VW), .Depth(MAX_V)) u_lv (.clk(clk), .we(lv_we), .waddr(lv_wa),
		.wdata(lv_wd), .raddr(lv_ra), .rdata(lv_rd));
	kscc_ram #(.Width(VW), .Depth(MAX_V)) u_lc (.clk(clk), .we(lc_we), .waddr(lc_wa),
		.wdata(lc_wd), .raddr(lc_ra), .rdata(lc_rd));

	// result port
	assign out_valid        = out_valid_q;
	assign kind             = o_kind_q;
	assign component_total  = o_total_q;
	assign edges_dropped    = o_drop_q;
	assign vertex_id        = o_vtx_q;
	assign component_number = o_comp_q;
	assign ends_component   = o_endc_q;
	assign ends_listing     = o_endl_q;

	// checks
	`KSCC_ASSERT_IMP(a_load_free, out_load, !out_valid_q, "result loaded over a pending one")
	`KSCC_ASSERT_IMP(a_depth_range, state_q == ST_TOP,
		depth_q != '0 && depth_q <= VW'(MAX_V), "walk depth out of range")
	`KSCC_ASSERT_IMP(a_rp_range, ready_q, rp_q <= len_q, "read pointer past listing")
	`KSCC_ASSERT_NXT(a_add_count, in_acc && mode_w == MODE_ADD && add_ok,
		et_q == $past(et_q) + CW'(1), "stored edge not counted")

endmodule
